@@ rtl/tvd_pkg.sv @@
// Shared types and widths for the TVD slope limiter.
// Used by the divider cells and the top level; depends on nothing.
package tvd_pkg;

  localparam int ValueWidth = 32;
  localparam int FracBits   = 16;
  // Magnitude width of a doubled difference.
  localparam int MagWidth   = ValueWidth + 2;
  // Quotient bits of the harmonic mean, one per divider cell.
  localparam int QuoWidth   = ValueWidth + 2;
  localparam int NumWidth   = 2 * (ValueWidth + 1);

  localparam logic [1:0] ModeSuperbee = 2'd0;
  localparam logic [1:0] ModeMinmod   = 2'd1;
  localparam logic [1:0] ModeVanLeer  = 2'd2;
  // Spare selector code: the limited slope is zero.
  localparam logic [1:0] ModeUnused   = 2'd3;

  // Partial division state handed from cell to cell.
  typedef struct packed {
    logic [QuoWidth-1:0] rem;
    logic [QuoWidth-1:0] low;
    logic [QuoWidth-1:0] quo;
    logic [QuoWidth-1:0] den;
  } div_t;

  // Request data that rides alongside the division.
  typedef struct packed {
    logic [MagWidth-1:0]   lim_mag;
    logic                  neg;
    logic [ValueWidth-1:0] inv;
    logic                  use_div;
  } side_t;

endpackage

@@ rtl/tvd_slope_limiter.sv @@
// Top level of the TVD slope limiter: limiter stage, divider cell chain
// and scaling stage. Depends on tvd_pkg and tvd_div_cell.
//
// Usage: a request is taken at each rising edge where start is high and
// busy is low. busy stays low, so a new request may follow in every cycle.
// Each request yields one result: slope and saturated are shown for one
// cycle with done high. The receiver cannot stall the block and needs none.
// Throughput is one request per cycle. The depth of the pipeline is set
// by the Van Leer harmonic mean: a chain of 34 restoring division cells,
// one quotient bit each, which every request passes through so that
// results stay in order. Around it sit a difference stage, a limiter
// stage, a product stage, the scaling multiply and the saturating output
// register. limiter_mode is written through cfg_valid/cfg_ready/cfg_data;
// the user must write it only while no request is in flight, as the block
// does not enforce this. cfg_ready is always high. Reset empties the
// pipeline and sets the mode to superbee.
module tvd_slope_limiter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tvd_pkg::ValueWidth-1:0] left_value,
  input  logic signed [tvd_pkg::ValueWidth-1:0] center_value,
  input  logic signed [tvd_pkg::ValueWidth-1:0] right_value,
  input  logic [tvd_pkg::ValueWidth-1:0]        inv_spacing,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_data,
  output logic                               done,
  output logic signed [tvd_pkg::ValueWidth-1:0] slope,
  output logic                               saturated
);

  localparam int W  = tvd_pkg::ValueWidth;
  localparam int MW = tvd_pkg::MagWidth;
  localparam int QW = tvd_pkg::QuoWidth;
  localparam int NW = tvd_pkg::NumWidth;

  logic [1:0] limiter_mode;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_mode <= tvd_pkg::ModeSuperbee;
    end else if (cfg_valid && cfg_ready) begin
      limiter_mode <= cfg_data;
    end
  end

  // Minmod or maxmod of two sign and magnitude values; returns {neg, mag}.
  function automatic logic [MW:0] pick(input logic na, input logic [MW-1:0] ma,
                                       input logic nb, input logic [MW-1:0] mb,
                                       input logic take_max);
    logic [MW:0] r;
    if (ma != '0 && mb != '0 && na != nb) begin
      r = '0;
    end else if (take_max) begin
      r = (ma > mb) ? {na, ma} : {nb, mb};
    end else begin
      r = (ma > mb) ? {nb, mb} : {na, ma};
    end
    return r;
  endfunction

  // Stage 1: differences.
  logic               s1_valid;
  logic signed [W:0]  s1_dl;
  logic signed [W:0]  s1_dr;
  logic [W-1:0]       s1_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_dl  <= {center_value[W-1], center_value} - {left_value[W-1], left_value};
    s1_dr  <= {right_value[W-1], right_value} - {center_value[W-1], center_value};
    s1_inv <= inv_spacing;
  end

  // Stage 2: limiter selection and Van Leer operands.
  logic [W:0]   a_mag;
  logic [W:0]   b_mag;
  logic         na;
  logic         nb;
  logic [MW:0]  sb1;
  logic [MW:0]  sb2;
  logic [MW:0]  sb;
  logic [MW:0]  mm;
  logic         vl_zero;
  tvd_pkg::side_t s2_side_next;

  always_comb begin
    na      = s1_dl[W];
    nb      = s1_dr[W];
    a_mag   = na ? -s1_dl : s1_dl;
    b_mag   = nb ? -s1_dr : s1_dr;
    sb1     = pick(na, {1'b0, a_mag}, nb, {b_mag, 1'b0}, 1'b0);
    sb2     = pick(na, {a_mag, 1'b0}, nb, {1'b0, b_mag}, 1'b0);
    sb      = pick(sb1[MW], sb1[MW-1:0], sb2[MW], sb2[MW-1:0], 1'b1);
    mm      = pick(na, {1'b0, a_mag}, nb, {1'b0, b_mag}, 1'b0);
    vl_zero = (a_mag == '0) || (b_mag == '0) || (na != nb);
    s2_side_next.inv     = s1_inv;
    s2_side_next.use_div = 1'b0;
    s2_side_next.lim_mag = '0;
    s2_side_next.neg     = 1'b0;
    unique case (limiter_mode)
      tvd_pkg::ModeSuperbee: begin
        s2_side_next.lim_mag = sb[MW-1:0];
        s2_side_next.neg     = sb[MW];
      end
      tvd_pkg::ModeMinmod: begin
        s2_side_next.lim_mag = mm[MW-1:0];
        s2_side_next.neg     = mm[MW];
      end
      tvd_pkg::ModeVanLeer: begin
        s2_side_next.use_div = !vl_zero;
        s2_side_next.neg     = na;
      end
      default: begin
        s2_side_next.lim_mag = '0;
      end
    endcase
  end

  logic           s2_valid;
  tvd_pkg::side_t s2_side;
  logic [W:0]     s2_a;
  logic [W:0]     s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_side <= s2_side_next;
    s2_a    <= a_mag;
    s2_b    <= b_mag;
  end

  // Stage 3: numerator 2ab and denominator a+b.
  logic [NW-1:0]  ab;
  logic [NW-1:0]  num;
  logic           s3_valid;
  tvd_pkg::side_t s3_side;
  tvd_pkg::div_t  s3_div;

  assign ab  = s2_a * s2_b;
  assign num = {ab[NW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_side    <= s2_side;
    s3_div.rem <= {{(2*QW-NW){1'b0}}, num[NW-1:QW]};
    s3_div.low <= num[QW-1:0];
    s3_div.quo <= '0;
    s3_div.den <= {1'b0, s2_a} + {1'b0, s2_b};
  end

  // Division cell chain.
  logic           cv [QW+1];
  tvd_pkg::div_t  cd [QW+1];
  tvd_pkg::side_t cs [QW+1];

  assign cv[0] = s3_valid;
  assign cd[0] = s3_div;
  assign cs[0] = s3_side;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    tvd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_div    (cd[i]),
      .in_side   (cs[i]),
      .out_valid (cv[i+1]),
      .out_div   (cd[i+1]),
      .out_side  (cs[i+1])
    );
  end

  // Scaling multiply.
  logic [MW-1:0]    fin_mag;
  logic             s4_valid;
  logic             s4_neg;
  logic [MW+W-1:0]  s4_prod;

  assign fin_mag = cs[QW].use_div ? cd[QW].quo : cs[QW].lim_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    s4_neg  <= cs[QW].neg;
    s4_prod <= fin_mag * cs[QW].inv;
  end

  // Truncate, saturate and apply the sign.
  logic [MW+W-tvd_pkg::FracBits-1:0] shifted;
  logic [W-1:0] limit;
  logic [W-1:0] mag_out;
  logic         sat_next;

  always_comb begin
    shifted  = s4_prod[MW+W-1:tvd_pkg::FracBits];
    limit    = s4_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat_next = (shifted[MW+W-tvd_pkg::FracBits-1:W] != '0) || (shifted[W-1:0] > limit);
    mag_out  = sat_next ? limit : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    slope     <= s4_neg ? -mag_out : mag_out;
    saturated <= sat_next;
  end

endmodule

@@ rtl/tvd_div_cell.sv @@
// One restoring division step: yields one quotient bit per cycle.
// Depends on tvd_pkg for div_t and side_t.
module tvd_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tvd_pkg::div_t  in_div,
  input  tvd_pkg::side_t in_side,
  output logic           out_valid,
  output tvd_pkg::div_t  out_div,
  output tvd_pkg::side_t out_side
);

  logic [tvd_pkg::QuoWidth:0] rem_sh;
  logic [tvd_pkg::QuoWidth:0] diff;
  tvd_pkg::div_t              div_next;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    rem_sh = {in_div.rem, in_div.low[tvd_pkg::QuoWidth-1]};
    diff   = rem_sh - {1'b0, in_div.den};
    div_next.den = in_div.den;
    div_next.low = {in_div.low[tvd_pkg::QuoWidth-2:0], 1'b0};
    if (rem_sh >= {1'b0, in_div.den}) begin
      div_next.rem = diff[tvd_pkg::QuoWidth-1:0];
      div_next.quo = {in_div.quo[tvd_pkg::QuoWidth-2:0], 1'b1};
    end else begin
      div_next.rem = rem_sh[tvd_pkg::QuoWidth-1:0];
      div_next.quo = {in_div.quo[tvd_pkg::QuoWidth-2:0], 1'b0};
    end
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_div  <= div_next;
    out_side <= in_side;
  end

endmodule
